// ===== rtl/stkph_pkg.sv =====
// ----------------------------------------------------------------------------
// stkph_pkg
// Shared types and constants of the sectioned top-k priority unit.
// ----------------------------------------------------------------------------
package stkph_pkg;

    // Operation codes
    localparam logic [2:0] FUNC_ADD   = 3'd0;
    localparam logic [2:0] FUNC_ERASE = 3'd1;
    localparam logic [2:0] FUNC_READ  = 3'd2;
    localparam logic [2:0] FUNC_MOVE  = 3'd3;
    localparam logic [2:0] FUNC_LIST  = 3'd4;

    localparam logic [31:0] READ_WEIGHT  = 32'd50000;
    localparam logic [31:0] RECENT_BONUS = 32'd500000;
    localparam logic [3:0]  NO_SECTION   = 4'd15;
    localparam logic [15:0] READ_MAX     = 16'hFFFF;

    // One item record as kept in the item memory
    typedef struct packed {
        logic        live;
        logic [3:0]  sec;
        logic [15:0] reads;
    } t_item;

    // Controls of the ranking unit
    typedef struct packed {
        logic clear;
        logic ins;
        logic pop;
    } t_rank_ctl;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_UPDATE,
        S_LUSER,
        S_SCAN,
        S_DRAIN,
        S_EMIT
    } t_state;

endpackage

// ===== rtl/stkph_ram.sv =====
// ----------------------------------------------------------------------------
// stkph_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module stkph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/stkph_rank.sv =====
// ----------------------------------------------------------------------------
// stkph_rank
// Sorted top-k register list: inserts one candidate per cycle, pops the head.
// ----------------------------------------------------------------------------
module stkph_rank
    import stkph_pkg::*;
#(
    parameter int LIST_LEN = 10,
    parameter int KW       = $clog2(LIST_LEN + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_rank_ctl     i_ctl,
    input  logic [31:0]   i_cand_score,
    input  logic [3:0]    i_cand_sec,
    input  logic [9:0]    i_cand_id,
    output logic [9:0]    o_head_id,
    output logic [KW-1:0] o_count
);

    logic [31:0]   r_score [LIST_LEN];
    logic [3:0]    r_sec   [LIST_LEN];
    logic [9:0]    r_id    [LIST_LEN];
    logic [KW-1:0] r_cnt;
    logic [LIST_LEN-1:0] better;

    // Candidate beats an empty slot, or an entry on higher score, then on lower section
    always_comb begin
        for (int j = 0; j < LIST_LEN; j++) begin
            better[j] = (32'(j) >= 32'(r_cnt)) || (i_cand_score > r_score[j]) ||
                        ((i_cand_score == r_score[j]) && (i_cand_sec < r_sec[j]));
        end
    end

    genvar j;
    generate
        for (j = 0; j < LIST_LEN; j++) begin : g_slot
            logic prev_better;
            if (j == 0) begin : g_first
                assign prev_better = 1'b0;
            end else begin : g_rest
                assign prev_better = better[j-1];
            end

            // Shift down on insert, shift up on pop
            always_ff @(posedge i_clk) begin
                if (i_ctl.ins) begin
                    if (better[j] && !prev_better) begin
                        r_score[j] <= i_cand_score;
                        r_sec[j]   <= i_cand_sec;
                        r_id[j]    <= i_cand_id;
                    end else if (prev_better) begin
                        if (j > 0) begin
                            r_score[j] <= r_score[(j > 0) ? j-1 : 0];
                            r_sec[j]   <= r_sec[(j > 0) ? j-1 : 0];
                            r_id[j]    <= r_id[(j > 0) ? j-1 : 0];
                        end
                    end
                end else if (i_ctl.pop) begin
                    if (j < LIST_LEN-1) begin
                        r_score[j] <= r_score[(j < LIST_LEN-1) ? j+1 : j];
                        r_sec[j]   <= r_sec[(j < LIST_LEN-1) ? j+1 : j];
                        r_id[j]    <= r_id[(j < LIST_LEN-1) ? j+1 : j];
                    end
                end
            end
        end
    endgenerate

    // Track fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_cnt <= '0;
        end else if (i_ctl.ins) begin
            if (32'(r_cnt) < 32'(LIST_LEN)) begin
                r_cnt <= r_cnt + KW'(1);
            end
        end else if (i_ctl.pop) begin
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - KW'(1);
            end
        end
    end

    assign o_head_id = r_id[0];
    assign o_count   = r_cnt;

endmodule

// ===== rtl/sectioned_top_k_priority_heaps_unit.sv =====
// ----------------------------------------------------------------------------
// sectioned_top_k_priority_heaps_unit
// Per-item section and read-count store with a ranked top-k list command.
// ----------------------------------------------------------------------------
// After reset the unit sweeps its item and user memories with busy high.
// Add, erase, read and move are a read-modify-write of the item memory and
// hold busy through the write-back state after accept, so a new command is
// taken only once that state is done. A list walks the whole item memory
// through its single read port, one item per cycle: busy stays high through
// the user read, the scan, the drain of the scoring pipeline and one emit
// step per listed entry, or one for an empty list. Each result beat is
// registered from its emit step and appears in the cycle after it, the last
// one in the first cycle with busy low. Results come out one beat per cycle
// on o_strobe and must be taken as they appear: the receiver cannot hold
// them off.
module sectioned_top_k_priority_heaps_unit
    import stkph_pkg::*;
#(
    parameter int ITEM_SLOTS    = 1024,
    parameter int SECTION_COUNT = 10,
    parameter int USER_SLOTS    = 1024,
    parameter int LIST_LEN      = 10
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic [2:0] i_func,
    input  logic [9:0] i_item_id,
    input  logic [3:0] i_section_sel,
    input  logic [9:0] i_user_id,
    output logic       busy,
    output logic       o_strobe,
    output logic       o_entry_valid,
    output logic [9:0] o_entry_id,
    output logic [3:0] o_entry_rank,
    output logic [3:0] o_list_count,
    output logic       o_last
);

    localparam int IW      = $clog2(ITEM_SLOTS);
    localparam int UW      = (USER_SLOTS > 1) ? $clog2(USER_SLOTS) : 1;
    localparam int CLR_LEN = (ITEM_SLOTS > USER_SLOTS) ? ITEM_SLOTS : USER_SLOTS;
    localparam int CW      = $clog2(CLR_LEN);
    localparam int KW      = $clog2(LIST_LEN + 1);
    localparam int TW      = $bits(t_item);

    t_state  r_state, n_state;
    logic [2:0]    r_func;
    logic [9:0]    r_id;
    logic [3:0]    r_sec;
    logic [UW-1:0] r_user;
    logic          r_id_ok, r_sec_ok, r_user_ok;
    logic [CW-1:0] r_clr;
    logic [IW-1:0] r_scan;
    logic          r_v1, r_v2;
    logic [IW-1:0] r_a1;
    logic [31:0]   r_sc;
    logic [3:0]    r_csec;
    logic [9:0]    r_cid;
    logic [3:0]    r_recent;
    logic [KW-1:0] r_total, r_rank;
    logic          r_strobe, r_evalid, r_last;
    logic [9:0]    r_eid;
    logic [3:0]    r_erank, r_ecount;

    logic          item_we, user_we;
    logic [IW-1:0] item_waddr, item_raddr;
    logic [UW-1:0] user_waddr, user_raddr;
    t_item         item_wdata, cur;
    logic [TW-1:0] item_rdata;
    logic [3:0]    user_wdata, user_rdata;
    t_rank_ctl     rank_ctl;
    logic [9:0]    head_id;
    logic [KW-1:0] rank_count;
    logic          emit_last, drain_done;
    logic [31:0]   a32, prod;

    assign cur        = t_item'(item_rdata);
    assign emit_last  = (r_total == '0) || (r_rank == r_total - KW'(1));
    assign drain_done = !r_v1 && !r_v2;

    stkph_ram #(.WIDTH(TW), .DEPTH(ITEM_SLOTS)) u_item_ram (
        .i_clk   (i_clk),
        .i_we    (item_we),
        .i_waddr (item_waddr),
        .i_wdata (item_wdata),
        .i_raddr (item_raddr),
        .o_rdata (item_rdata)
    );

    stkph_ram #(.WIDTH(4), .DEPTH(USER_SLOTS)) u_user_ram (
        .i_clk   (i_clk),
        .i_we    (user_we),
        .i_waddr (user_waddr),
        .i_wdata (user_wdata),
        .i_raddr (user_raddr),
        .o_rdata (user_rdata)
    );

    stkph_rank #(.LIST_LEN(LIST_LEN)) u_rank (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (rank_ctl),
        .i_cand_score (r_sc),
        .i_cand_sec   (r_csec),
        .i_cand_id    (r_cid),
        .o_head_id    (head_id),
        .o_count      (rank_count)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (32'(r_clr) == 32'(CLR_LEN - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) n_state = (i_func == FUNC_LIST) ? S_LUSER : S_UPDATE;
            end
            S_UPDATE: n_state = S_IDLE;
            S_LUSER:  n_state = S_SCAN;
            S_SCAN: begin
                if (32'(r_scan) == 32'(ITEM_SLOTS - 1)) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (drain_done) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (emit_last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Memory ports and ranking controls
    always_comb begin
        item_we    = 1'b0;
        item_waddr = IW'(r_id);
        item_wdata = cur;
        item_raddr = r_scan;
        user_we    = 1'b0;
        user_waddr = r_user;
        user_wdata = cur.sec;
        user_raddr = UW'(i_user_id);
        rank_ctl   = '{clear: 1'b0, ins: r_v2, pop: 1'b0};
        busy       = (r_state != S_IDLE);
        case (r_state)
            S_CLEAR: begin
                item_we    = 32'(r_clr) < 32'(ITEM_SLOTS);
                item_waddr = IW'(r_clr);
                item_wdata = '0;
                user_we    = 32'(r_clr) < 32'(USER_SLOTS);
                user_waddr = UW'(r_clr);
                user_wdata = NO_SECTION;
            end
            S_IDLE: begin
                item_raddr = IW'(i_item_id);
            end
            S_UPDATE: begin
                case (r_func)
                    FUNC_ADD: begin
                        item_we    = r_id_ok && r_sec_ok && !cur.live;
                        item_wdata = '{live: 1'b1, sec: r_sec, reads: '0};
                    end
                    FUNC_ERASE: begin
                        item_we         = r_id_ok && cur.live;
                        item_wdata.live = 1'b0;
                    end
                    FUNC_READ: begin
                        item_we = r_id_ok && cur.live;
                        if (cur.reads != READ_MAX) item_wdata.reads = cur.reads + 16'd1;
                        user_we = r_id_ok && cur.live && r_user_ok;
                    end
                    FUNC_MOVE: begin
                        item_we        = r_id_ok && r_sec_ok && cur.live;
                        item_wdata.sec = r_sec;
                    end
                    default: item_we = 1'b0;
                endcase
            end
            S_LUSER: rank_ctl.clear = 1'b1;
            S_EMIT:  rank_ctl.pop = 1'b1;
            default: item_we = 1'b0;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= r_clr + CW'(1);
            r_v1     <= (r_state == S_SCAN);
            r_v2     <= r_v1 && cur.live;
            r_strobe <= (r_state == S_EMIT);
        end
    end

    assign a32  = 32'(r_a1);
    assign prod = 32'(cur.reads) * READ_WEIGHT;

    // Capture command, walk the items, score and emit
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_func    <= i_func;
            r_id      <= i_item_id;
            r_sec     <= i_section_sel;
            r_user    <= UW'(i_user_id);
            r_id_ok   <= 32'(i_item_id) < 32'(ITEM_SLOTS);
            r_sec_ok  <= 32'(i_section_sel) < 32'(SECTION_COUNT);
            r_user_ok <= 32'(i_user_id) < 32'(USER_SLOTS);
        end
        if (r_state == S_LUSER) begin
            r_recent <= r_user_ok ? user_rdata : NO_SECTION;
            r_scan   <= '0;
        end else if (r_state == S_SCAN) begin
            r_scan <= r_scan + IW'(1);
        end
        r_a1   <= r_scan;
        r_sc   <= prod + 32'(a32[9:0]) + ((cur.sec == r_recent) ? RECENT_BONUS : 32'd0);
        r_csec <= cur.sec;
        r_cid  <= a32[9:0];
        if (r_state == S_DRAIN) begin
            r_total <= rank_count;
            r_rank  <= '0;
        end else if (r_state == S_EMIT) begin
            r_rank <= r_rank + KW'(1);
        end
        r_evalid <= (r_total != '0);
        r_eid    <= (r_total != '0) ? head_id : 10'd0;
        r_erank  <= 4'(r_rank);
        r_ecount <= 4'(r_total);
        r_last   <= emit_last;
    end

    assign o_strobe      = r_strobe;
    assign o_entry_valid = r_evalid;
    assign o_entry_id    = r_eid;
    assign o_entry_rank  = r_erank;
    assign o_list_count  = r_ecount;
    assign o_last        = r_last;

endmodule

// ===== rtl/stkph_checker.sv =====
// ----------------------------------------------------------------------------
// stkph_checker
// Port-level checks of the list result sequence and command acceptance.
// ----------------------------------------------------------------------------
module stkph_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_strobe,
    input logic       o_entry_valid,
    input logic [9:0] o_entry_id,
    input logic [3:0] o_entry_rank,
    input logic [3:0] o_list_count,
    input logic       o_last
);

    // Empty list is one final beat with zero count
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_entry_valid |-> o_last && o_list_count == 4'd0 && o_entry_id == 10'd0)
        else $error("empty list beat malformed");

    // Rank stays below count
    a_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_entry_valid |-> o_entry_rank < o_list_count)
        else $error("rank out of range");

    // Final beat carries the last rank
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_entry_valid && o_last |-> o_entry_rank == o_list_count - 4'd1)
        else $error("last beat rank wrong");

    // Beats of one list follow back to back with rising rank
    a_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |=> o_strobe && o_entry_rank == $past(o_entry_rank) + 4'd1)
        else $error("list beats broken");

    // An accepted command raises busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

endmodule

bind sectioned_top_k_priority_heaps_unit stkph_checker u_stkph_checker (.*);

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the sectioned top-k priority unit. A queue of commands feeds
// a driver at the falling edge; a monitor at the rising edge updates a
// shadow of the item and user tables on every accepted beat, predicts the
// ranked list for each list command and checks every strobed result.
// ----------------------------------------------------------------------------
module tb_top;
    import stkph_pkg::*;

    localparam int NUM_ITEMS    = 1024;
    localparam int NUM_SECTIONS = 10;
    localparam int NUM_USERS    = 1024;
    localparam int TOP_K        = 10;
    localparam int IDLE_LIMIT   = 6000;

    typedef struct {
        logic [2:0] func;
        logic [9:0] item_id;
        logic [3:0] section_sel;
        logic [9:0] user_id;
        bit         drain_first;
    } t_cmd;

    typedef struct {
        logic       valid;
        logic [9:0] id;
        logic [3:0] rank;
        logic [3:0] count;
        logic       last;
    } t_entry;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic [2:0] i_func = '0;
    logic [9:0] i_item_id = '0;
    logic [3:0] i_section_sel = '0;
    logic [9:0] i_user_id = '0;
    logic       busy, o_strobe, o_entry_valid, o_last;
    logic [9:0] o_entry_id;
    logic [3:0] o_entry_rank, o_list_count;

    // Shadow of the unit state
    bit          item_live   [NUM_ITEMS];
    logic [3:0]  item_sec    [NUM_ITEMS];
    logic [15:0] item_reads  [NUM_ITEMS];
    logic [3:0]  user_recent [NUM_USERS];

    t_cmd   cmd_q[$];
    t_entry list_q[$];
    int     n_accepted = 0;
    int     n_errors = 0;
    int     idle_cycles = 0;

    sectioned_top_k_priority_heaps_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_func(i_func),
        .i_item_id(i_item_id), .i_section_sel(i_section_sel),
        .i_user_id(i_user_id), .busy(busy), .o_strobe(o_strobe),
        .o_entry_valid(o_entry_valid), .o_entry_id(o_entry_id),
        .o_entry_rank(o_entry_rank), .o_list_count(o_list_count),
        .o_last(o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Score of a live item: read weight plus id, with the recent bonus
    function automatic longint unsigned item_score(int id, logic [3:0] recent);
        longint unsigned s;
        s = longint'(item_reads[id]) * longint'(READ_WEIGHT) + longint'(id);
        if (item_sec[id] == recent) s += longint'(RECENT_BONUS);
        return s;
    endfunction

    // Build the expected ranked list for one user
    task automatic predict_list(logic [9:0] user);
        logic [3:0]      recent;
        bit              taken[NUM_ITEMS];
        int              picked[$];
        int              best_id;
        longint unsigned best, sc;
        t_entry          e;
        recent = user_recent[user];
        for (int k = 0; k < TOP_K; k++) begin
            best_id = -1;
            best = 0;
            for (int id = 0; id < NUM_ITEMS; id++) begin
                if (item_live[id] && !taken[id]) begin
                    sc = item_score(id, recent);
                    if (best_id < 0 || sc > best) begin
                        best = sc;
                        best_id = id;
                    end
                end
            end
            if (best_id < 0) break;
            taken[best_id] = 1'b1;
            picked.push_back(best_id);
        end
        if (picked.size() == 0) begin
            e = '{1'b0, 10'd0, 4'd0, 4'd0, 1'b1};
            list_q.push_back(e);
        end
        for (int i = 0; i < picked.size(); i++) begin
            e.valid = 1'b1;
            e.id    = 10'(picked[i]);
            e.rank  = 4'(i);
            e.count = 4'(picked.size());
            e.last  = (i == picked.size() - 1);
            list_q.push_back(e);
        end
    endtask

    // Apply one accepted command to the shadow state
    task automatic apply_cmd(logic [2:0] func, logic [9:0] id, logic [3:0] sec,
                             logic [9:0] user);
        case (func)
            FUNC_ADD: begin
                if (sec < NUM_SECTIONS && !item_live[id]) begin
                    item_live[id] = 1'b1;
                    item_sec[id] = sec;
                    item_reads[id] = '0;
                end
            end
            FUNC_ERASE: item_live[id] = 1'b0;
            FUNC_READ: begin
                if (item_live[id]) begin
                    if (item_reads[id] != READ_MAX) item_reads[id]++;
                    user_recent[user] = item_sec[id];
                end
            end
            FUNC_MOVE: begin
                if (sec < NUM_SECTIONS && item_live[id]) item_sec[id] = sec;
            end
            FUNC_LIST: predict_list(user);
            default: ;
        endcase
    endtask

    // Driver: present the head command unless idling or draining
    always @(negedge i_clk) begin
        int  idle_pct;
        bit  go;
        idle_pct = (n_accepted < 117) ? 19 : (n_accepted < 234) ? 47 : 0;
        go = i_rst_n && cmd_q.size() > 0 && $urandom_range(99) >= idle_pct;
        if (go && cmd_q[0].drain_first && list_q.size() > 0) go = 1'b0;
        if (go) begin
            start <= 1'b1;
            i_func <= cmd_q[0].func;
            i_item_id <= cmd_q[0].item_id;
            i_section_sel <= cmd_q[0].section_sel;
            i_user_id <= cmd_q[0].user_id;
        end else begin
            start <= 1'b0;
        end
    end

    // Monitor: take accepted beats and check strobed results
    always @(posedge i_clk) begin
        t_entry e;
        if (i_rst_n && start && !busy) begin
            apply_cmd(i_func, i_item_id, i_section_sel, i_user_id);
            void'(cmd_q.pop_front());
            n_accepted++;
        end
        if (i_rst_n && o_strobe) begin
            if (list_q.size() == 0) begin
                $display("%0t: unexpected result id %0d", $realtime, o_entry_id);
                n_errors++;
            end else begin
                e = list_q.pop_front();
                if (o_entry_valid !== e.valid || o_entry_id !== e.id ||
                    o_entry_rank !== e.rank || o_list_count !== e.count ||
                    o_last !== e.last) begin
                    $display("%0t: expected v%0d id%0d rank%0d cnt%0d last%0d",
                             $realtime, e.valid, e.id, e.rank, e.count, e.last);
                    $display("%0t: actual   v%0d id%0d rank%0d cnt%0d last%0d",
                             $realtime, o_entry_valid, o_entry_id, o_entry_rank,
                             o_list_count, o_last);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog: count cycles in which no beat moves
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    task automatic push_cmd(logic [2:0] f, logic [9:0] id, logic [3:0] sec,
                            logic [9:0] user, bit drain = 1'b0);
        t_cmd c;
        c = '{f, id, sec, user, drain};
        cmd_q.push_back(c);
    endtask

    initial begin
        int          pick;
        logic [2:0]  f;
        logic [9:0]  id, user;
        logic [3:0]  sec;
        for (int i = 0; i < NUM_ITEMS; i++) begin
            item_live[i] = 1'b0;
            item_reads[i] = '0;
            item_sec[i] = '0;
        end
        for (int u = 0; u < NUM_USERS; u++) user_recent[u] = NO_SECTION;

        // Directed: empty list, extremes, ignored cases, bonus on and off
        push_cmd(FUNC_LIST, 10'd0, 4'd0, 10'd0);
        push_cmd(FUNC_ADD, 10'd0, 4'd0, 10'd0);
        push_cmd(FUNC_ADD, 10'd1023, 4'd9, 10'd1023);
        push_cmd(FUNC_ADD, 10'd5, 4'd15, 10'd0);
        push_cmd(FUNC_ADD, 10'd6, 4'd10, 10'd0);
        push_cmd(FUNC_ADD, 10'd0, 4'd3, 10'd0);
        push_cmd(FUNC_ERASE, 10'd77, 4'd0, 10'd0);
        push_cmd(FUNC_READ, 10'd78, 4'd0, 10'd5);
        push_cmd(FUNC_MOVE, 10'd79, 4'd2, 10'd0);
        push_cmd(3'd5, 10'h3FF, 4'hF, 10'h3FF);
        push_cmd(3'd6, 10'd1, 4'd1, 10'd1);
        push_cmd(3'd7, 10'd2, 4'd2, 10'd2);
        push_cmd(FUNC_READ, 10'd0, 4'd0, 10'd1023);
        push_cmd(FUNC_LIST, 10'd0, 4'd0, 10'd1023);
        push_cmd(FUNC_LIST, 10'd0, 4'd0, 10'd3);
        push_cmd(FUNC_MOVE, 10'd0, 4'd9, 10'd0);
        push_cmd(FUNC_MOVE, 10'd1023, 4'd12, 10'd0);
        for (int i = 0; i < 11; i++) push_cmd(FUNC_ADD, 10'(100 + i), 4'(i % 10), 10'd0);
        push_cmd(FUNC_LIST, 10'd0, 4'd0, 10'd1023);
        push_cmd(FUNC_ERASE, 10'd1023, 4'd0, 10'd0);
        push_cmd(FUNC_LIST, 10'd0, 4'd0, 10'd0, 1'b1);

        // Random: a small pool of ids and users keeps items live and reread
        for (int n = 0; n < 330; n++) begin
            pick = $urandom_range(99);
            f = pick < 28 ? FUNC_ADD : pick < 38 ? FUNC_ERASE : pick < 66 ? FUNC_READ :
                pick < 78 ? FUNC_MOVE : pick < 95 ? FUNC_LIST : 3'($urandom_range(7, 5));
            id = ($urandom_range(9) == 0) ? 10'($urandom_range(1023)) :
                                            10'($urandom_range(40));
            sec = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) :
                                             4'($urandom_range(9));
            user = ($urandom_range(7) == 0) ? 10'($urandom_range(1023)) :
                                              10'($urandom_range(7));
            push_cmd(f, id, sec, user, (n % 40) == 39);
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Wait out the stimulus, the expected results, then a short tail
        while (cmd_q.size() > 0 || list_q.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
